@@ design/framed_packet_receiver_crc16_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet receiver
// Short forms of the concurrent assertions used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_CRC16_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_CRC16_MACROS_SVH

// Checked on every rising edge of clk_i once reset has been released.
`define FPRX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, also while reset is asserted.
`define FPRX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/fprx_pkg.sv @@
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Parser phases, frame constants, register map and the byte-wide CRC16 update.
// ----------------------------------------------------------------------------
package fprx_pkg;

  // Default for the largest accepted payload length.
  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  // Frame header bytes.
  localparam logic [7:0] SYNC_BYTE_1 = 8'hAA;
  localparam logic [7:0] SYNC_BYTE_2 = 8'h55;

  // CRC-16/CCITT-FALSE: polynomial and start value.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Timeout register reset value in milliseconds.
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  // Register map: APB address width and register index of each register.
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_IDX_TIMEOUT = 1'b0;

  // Input command codes.
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_TYPE = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CRCL = 3'd5,
    PH_CRCH = 3'd6
  } phase_e;

  // One byte of CRC update, most significant bit first, unrolled over 8 bits.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ design/framed_packet_receiver_crc16.sv @@
// ----------------------------------------------------------------------------
// Framed packet receiver with CRC16 check
// Parses 0xAA 0x55 TYPE LEN PAYLOAD CRC_LO CRC_HI frames from a byte stream,
// keeps frame statistics and timestamps on a millisecond time base, and
// reports whether a valid frame arrived within the online timeout.
// ----------------------------------------------------------------------------
// Each input word is either a received byte or a one-millisecond tick, and
// each accepted word yields exactly one result word. The block takes one word
// per clock cycle while out_stall_i does not hold it back. An accepted word
// is first captured in an input register; from there the parser, the
// byte-wide CRC update and the statistics are evaluated and loaded into the
// result registers, which offer the result. The input register lets one more word
// be taken while a result waits on out_stall_i. The online timeout is set
// through the APB register at byte address 0 and should be changed only while
// no word is in flight.

`include "framed_packet_receiver_crc16_macros.svh"

module framed_packet_receiver_crc16 import fprx_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [7:0]            rx_byte_i,
  // Output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  frame_ok_o,
  output logic                  crc_error_o,
  output logic                  length_error_o,
  output logic [7:0]            last_frame_type_o,
  output logic [7:0]            seq_number_o,
  output logic                  online_o,
  output logic [31:0]           byte_count_o,
  output logic [31:0]           good_frame_count_o,
  output logic [31:0]           crc_error_count_o,
  output logic [31:0]           length_error_count_o,
  output logic [31:0]           last_activity_time_o,
  output logic [31:0]           last_good_time_o
);

  localparam logic [7:0] MaxLen = 8'(MaxPayload);

  // Configuration register.
  logic [31:0] timeout_q;
  logic        cfg_wr;

  // Input register.
  logic        in_valid_q, in_valid_d;
  logic        in_load;
  cmd_e        cmd_q;
  logic [7:0]  byte_q;

  // Pipeline control.
  logic        advance;
  logic        out_valid_q, out_valid_d;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [31:0] time_q, time_d;

  // Statistics and result registers.
  logic [31:0] byte_cnt_q, byte_cnt_d;
  logic [31:0] good_cnt_q, good_cnt_d;
  logic [31:0] crc_cnt_q, crc_cnt_d;
  logic [31:0] len_cnt_q, len_cnt_d;
  logic [31:0] act_time_q, act_time_d;
  logic [31:0] good_time_q, good_time_d;
  logic [7:0]  last_type_q, last_type_d;
  logic [7:0]  last_seq_q, last_seq_d;
  logic        ok_q, ok_d;
  logic        cerr_q, cerr_d;
  logic        lerr_q, lerr_d;
  logic        online_q, online_d;

  // Intermediate values.
  logic [15:0] crc_next;
  logic [15:0] crc_seed;
  logic [7:0]  pos_inc;
  logic [31:0] elapsed;

  // APB register access; the register index is the word address.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_TIMEOUT);
  assign prdata = (paddr[2] == REG_IDX_TIMEOUT) ? timeout_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_q <= pwdata;
    end
  end

  // Handshake: the compute stage moves when the result register is free.
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_load     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      cmd_q  <= cmd_e'(cmd_i);
      byte_q <= rx_byte_i;
    end
  end

  // CRC update of the current byte; the type byte starts from the init value.
  assign crc_seed = (phase_q == PH_TYPE) ? CRC_INIT : crc_q;
  assign crc_next = crc16_byte(crc_seed, byte_q);
  assign pos_inc  = pos_q + 8'd1;

  // Parser and statistics update for one word.
  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    len_d       = len_q;
    pos_d       = pos_q;
    first_d     = first_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    time_d      = time_q;
    byte_cnt_d  = byte_cnt_q;
    good_cnt_d  = good_cnt_q;
    crc_cnt_d   = crc_cnt_q;
    len_cnt_d   = len_cnt_q;
    act_time_d  = act_time_q;
    good_time_d = good_time_q;
    last_type_d = last_type_q;
    last_seq_d  = last_seq_q;
    ok_d        = 1'b0;
    cerr_d      = 1'b0;
    lerr_d      = 1'b0;

    if (cmd_q == CMD_TICK) begin
      time_d = time_q + 32'd1;
    end else begin
      byte_cnt_d = byte_cnt_q + 32'd1;
      act_time_d = time_q;
      unique case (phase_q)
        PH_HDR1: begin
          if (byte_q == SYNC_BYTE_1) begin
            phase_d = PH_HDR2;
          end
        end
        PH_HDR2: begin
          // A repeated first sync byte keeps waiting for the second one.
          if (byte_q == SYNC_BYTE_2) begin
            phase_d = PH_TYPE;
          end else if (byte_q != SYNC_BYTE_1) begin
            phase_d = PH_HDR1;
          end
        end
        PH_TYPE: begin
          type_d  = byte_q;
          crc_d   = crc_next;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d = byte_q;
          pos_d = 8'd0;
          crc_d = crc_next;
          if (byte_q > MaxLen) begin
            len_cnt_d = len_cnt_q + 32'd1;
            lerr_d    = 1'b1;
            phase_d   = PH_HDR1;
            len_d     = 8'd0;
          end else if (byte_q == 8'd0) begin
            phase_d = PH_CRCL;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          if (pos_q == 8'd0) begin
            first_d = byte_q;
          end
          pos_d = pos_inc;
          crc_d = crc_next;
          if (pos_inc >= len_q) begin
            phase_d = PH_CRCL;
          end
        end
        PH_CRCL: begin
          crc_lo_d = byte_q;
          phase_d  = PH_CRCH;
        end
        PH_CRCH: begin
          if ({byte_q, crc_lo_q} == crc_q) begin
            good_cnt_d  = good_cnt_q + 32'd1;
            good_time_d = time_q;
            last_type_d = type_q;
            last_seq_d  = (len_q != 8'd0) ? first_q : 8'd0;
            ok_d        = 1'b1;
          end else begin
            crc_cnt_d = crc_cnt_q + 32'd1;
            cerr_d    = 1'b1;
          end
          phase_d = PH_HDR1;
          len_d   = 8'd0;
          pos_d   = 8'd0;
        end
        default: begin
          // Unused phase code: restart the parser.
          phase_d = PH_HDR1;
          len_d   = 8'd0;
          pos_d   = 8'd0;
        end
      endcase
    end
  end

  // Online status; a good frame in this word means zero elapsed time.
  assign elapsed  = time_d - good_time_q;
  assign online_d = (good_cnt_d != 32'd0) && (ok_d || (elapsed <= timeout_q));

  // State and result registers, loaded as each word completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR1;
      type_q      <= 8'd0;
      len_q       <= 8'd0;
      pos_q       <= 8'd0;
      first_q     <= 8'd0;
      crc_q       <= 16'd0;
      crc_lo_q    <= 8'd0;
      time_q      <= 32'd0;
      byte_cnt_q  <= 32'd0;
      good_cnt_q  <= 32'd0;
      crc_cnt_q   <= 32'd0;
      len_cnt_q   <= 32'd0;
      act_time_q  <= 32'd0;
      good_time_q <= 32'd0;
      last_type_q <= 8'd0;
      last_seq_q  <= 8'd0;
      ok_q        <= 1'b0;
      cerr_q      <= 1'b0;
      lerr_q      <= 1'b0;
      online_q    <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      type_q      <= type_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      first_q     <= first_d;
      crc_q       <= crc_d;
      crc_lo_q    <= crc_lo_d;
      time_q      <= time_d;
      byte_cnt_q  <= byte_cnt_d;
      good_cnt_q  <= good_cnt_d;
      crc_cnt_q   <= crc_cnt_d;
      len_cnt_q   <= len_cnt_d;
      act_time_q  <= act_time_d;
      good_time_q <= good_time_d;
      last_type_q <= last_type_d;
      last_seq_q  <= last_seq_d;
      ok_q        <= ok_d;
      cerr_q      <= cerr_d;
      lerr_q      <= lerr_d;
      online_q    <= online_d;
    end
  end

  // Result word.
  assign frame_ok_o           = ok_q;
  assign crc_error_o          = cerr_q;
  assign length_error_o       = lerr_q;
  assign last_frame_type_o    = last_type_q;
  assign seq_number_o         = last_seq_q;
  assign online_o             = online_q;
  assign byte_count_o         = byte_cnt_q;
  assign good_frame_count_o   = good_cnt_q;
  assign crc_error_count_o    = crc_cnt_q;
  assign length_error_count_o = len_cnt_q;
  assign last_activity_time_o = act_time_q;
  assign last_good_time_o     = good_time_q;

  // Assertions.
  `FPRX_ASSERT(a_one_event, $onehot0({frame_ok_o, crc_error_o, length_error_o}), "event clash")
  `FPRX_ASSERT(a_good_stamp, frame_ok_o |-> last_good_time_o == last_activity_time_o, "bad stamp")
  `FPRX_ASSERT_ALWAYS(a_stall_full, in_stall_o |-> out_valid_o && out_stall_i, "needless stall")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Streams received bytes and millisecond ticks into the receiver, predicts
// every status word from a behavioral parser kept inside the bench, and checks
// each returned word field by field. Both sides idle at random. The online
// timeout is changed between phases while the receiver is empty.
// ----------------------------------------------------------------------------
module testbench;
  import fprx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AFTER = 300;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES = 4;

  // One input word: a byte or a tick.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } word_t;

  // One status word as returned by the receiver.
  typedef struct packed {
    logic        frame_ok;
    logic        crc_error;
    logic        length_error;
    logic [7:0]  last_frame_type;
    logic [7:0]  seq_number;
    logic        online;
    logic [31:0] byte_count;
    logic [31:0] good_frame_count;
    logic [31:0] crc_error_count;
    logic [31:0] length_error_count;
    logic [31:0] last_activity_time;
    logic [31:0] last_good_time;
  } status_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i;
  logic in_stall_o;
  logic cmd_i;
  logic [7:0] rx_byte_i;
  logic out_valid_o;
  logic out_stall_i;
  logic frame_ok_o;
  logic crc_error_o;
  logic length_error_o;
  logic [7:0] last_frame_type_o;
  logic [7:0] seq_number_o;
  logic online_o;
  logic [31:0] byte_count_o;
  logic [31:0] good_frame_count_o;
  logic [31:0] crc_error_count_o;
  logic [31:0] length_error_count_o;
  logic [31:0] last_activity_time_o;
  logic [31:0] last_good_time_o;

  framed_packet_receiver_crc16 dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .cmd_i                (cmd_i),
    .rx_byte_i            (rx_byte_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .frame_ok_o           (frame_ok_o),
    .crc_error_o          (crc_error_o),
    .length_error_o       (length_error_o),
    .last_frame_type_o    (last_frame_type_o),
    .seq_number_o         (seq_number_o),
    .online_o             (online_o),
    .byte_count_o         (byte_count_o),
    .good_frame_count_o   (good_frame_count_o),
    .crc_error_count_o    (crc_error_count_o),
    .length_error_count_o (length_error_count_o),
    .last_activity_time_o (last_activity_time_o),
    .last_good_time_o     (last_good_time_o)
  );

  // Words waiting to be sent and status words waiting to be returned.
  word_t   byte_stream_q[$];
  status_t expected_status[$];

  // Bench control.
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          idle_on = 1'b1;
  bit          tick_mix = 1'b0;
  bit          in_taken = 1'b0;
  word_t       next_word;
  status_t     want_status;

  // Parser image: configuration, parse state and statistics.
  logic [31:0] timeout_copy = TIMEOUT_RESET;
  phase_e      rx_phase = PH_HDR1;
  logic [7:0]  hold_type = '0;
  logic [7:0]  hold_len = '0;
  logic [7:0]  data_index = '0;
  logic [7:0]  hold_first = '0;
  logic [15:0] crc_acc = '0;
  logic [15:0] crc_got = '0;
  logic [31:0] ms_now = '0;
  logic [31:0] n_bytes = '0;
  logic [31:0] n_good = '0;
  logic [31:0] n_crc_err = '0;
  logic [31:0] n_len_err = '0;
  logic [31:0] act_stamp = '0;
  logic [31:0] good_stamp = '0;
  logic [7:0]  shown_type = '0;
  logic [7:0]  shown_seq = '0;

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // CRC-16/CCITT-FALSE, one data bit at a time, most significant bit first.
  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic restart_parser();
    rx_phase = PH_HDR1;
    hold_len = '0;
    data_index = '0;
  endtask

  // Advance the parser image by one accepted word and queue its status word.
  task automatic parse_word(input cmd_e c, input logic [7:0] b);
    status_t s;
    s = '0;
    if (c == CMD_TICK) begin
      ms_now = ms_now + 32'd1;
    end else begin
      n_bytes = n_bytes + 32'd1;
      act_stamp = ms_now;
      case (rx_phase)
        PH_HDR1: begin
          if (b == SYNC_BYTE_1) rx_phase = PH_HDR2;
        end
        PH_HDR2: begin
          if (b == SYNC_BYTE_2) begin
            rx_phase = PH_TYPE;
          end else if (b != SYNC_BYTE_1) begin
            rx_phase = PH_HDR1;
          end
        end
        PH_TYPE: begin
          hold_type = b;
          crc_acc = crc16_next(CRC_INIT, b);
          rx_phase = PH_LEN;
        end
        PH_LEN: begin
          hold_len = b;
          data_index = '0;
          crc_acc = crc16_next(crc_acc, b);
          if (b > MAX_PAYLOAD_DEF) begin
            n_len_err = n_len_err + 32'd1;
            s.length_error = 1'b1;
            restart_parser();
          end else if (b == 8'd0) begin
            rx_phase = PH_CRCL;
          end else begin
            rx_phase = PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_index == 8'd0) hold_first = b;
          data_index = data_index + 8'd1;
          crc_acc = crc16_next(crc_acc, b);
          if (data_index >= hold_len) rx_phase = PH_CRCL;
        end
        PH_CRCL: begin
          crc_got = {8'h00, b};
          rx_phase = PH_CRCH;
        end
        PH_CRCH: begin
          crc_got = {b, crc_got[7:0]};
          if (crc_got == crc_acc) begin
            n_good = n_good + 32'd1;
            good_stamp = ms_now;
            shown_type = hold_type;
            shown_seq = (hold_len != 8'd0) ? hold_first : 8'd0;
            s.frame_ok = 1'b1;
          end else begin
            n_crc_err = n_crc_err + 32'd1;
            s.crc_error = 1'b1;
          end
          restart_parser();
        end
        default: begin
          restart_parser();
        end
      endcase
    end
    s.last_frame_type = shown_type;
    s.seq_number = shown_seq;
    s.online = (n_good != 32'd0) && ((ms_now - good_stamp) <= timeout_copy);
    s.byte_count = n_bytes;
    s.good_frame_count = n_good;
    s.crc_error_count = n_crc_err;
    s.length_error_count = n_len_err;
    s.last_activity_time = act_stamp;
    s.last_good_time = good_stamp;
    expected_status.push_back(s);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: mismatch in %s: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Input acceptance and status word checking, both sampled at the rising edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        parse_word(cmd_e'(cmd_i), rx_byte_i);
        words_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_status.size() == 0) begin
          $display("%0t: status word with none expected", $time);
          errors++;
        end else begin
          want_status = expected_status.pop_front();
          check_field("frame_ok", 32'(want_status.frame_ok), 32'(frame_ok_o));
          check_field("crc_error", 32'(want_status.crc_error), 32'(crc_error_o));
          check_field("length_error", 32'(want_status.length_error), 32'(length_error_o));
          check_field("last_frame_type", 32'(want_status.last_frame_type),
                      32'(last_frame_type_o));
          check_field("seq_number", 32'(want_status.seq_number), 32'(seq_number_o));
          check_field("online", 32'(want_status.online), 32'(online_o));
          check_field("byte_count", want_status.byte_count, byte_count_o);
          check_field("good_frame_count", want_status.good_frame_count, good_frame_count_o);
          check_field("crc_error_count", want_status.crc_error_count, crc_error_count_o);
          check_field("length_error_count", want_status.length_error_count,
                      length_error_count_o);
          check_field("last_activity_time", want_status.last_activity_time,
                      last_activity_time_o);
          check_field("last_good_time", want_status.last_good_time, last_good_time_o);
          results_checked++;
        end
      end
    end
  end

  // Sender: offers queued words, with random gaps after accepted words.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (in_taken && idle_on && send_gap == 0 && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 8);
      end
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (byte_stream_q.size() != 0) begin
        next_word = byte_stream_q.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= next_word.cmd;
        rx_byte_i <= next_word.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts and one long hold to back the block up.
  always @(negedge clk_i) begin
    if (!hold_done && words_accepted >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_tick();
    byte_stream_q.push_back('{cmd: CMD_TICK, data: 8'($urandom)});
    words_queued++;
  endtask

  // Queue one byte, now and then preceded by a tick when ticks are mixed in.
  task automatic queue_byte(input logic [7:0] b);
    if (tick_mix && $urandom_range(0, 15) == 0) queue_tick();
    byte_stream_q.push_back('{cmd: CMD_BYTE, data: b});
    words_queued++;
  endtask

  // Queue a frame; an oversize length ends it right after the length byte.
  task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] flen, input bit bad);
    logic [15:0] crc;
    logic [7:0] b;
    queue_byte(SYNC_BYTE_1);
    queue_byte(SYNC_BYTE_2);
    queue_byte(ftype);
    crc = crc16_next(CRC_INIT, ftype);
    queue_byte(flen);
    crc = crc16_next(crc, flen);
    if (flen > MAX_PAYLOAD_DEF) return;
    for (int i = 0; i < flen; i++) begin
      b = 8'($urandom);
      queue_byte(b);
      crc = crc16_next(crc, b);
    end
    if (bad) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    queue_byte(crc[7:0]);
    queue_byte(crc[15:8]);
  endtask

  // Payload lengths: mostly short, some empty, now and then the maximum.
  function automatic logic [7:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'(MAX_PAYLOAD_DEF);
    if (r <= 3) return 8'd0;
    if (r <= 15) return 8'($urandom_range(1, 6));
    return 8'($urandom_range(7, 24));
  endfunction

  // Mostly well-formed frames with random content, plus ticks, noise,
  // oversize lengths, header glitches and cut-off frames.
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned stop;
    int unsigned pick;
    stop = words_queued + count;
    while (words_queued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_frame(8'($urandom), pick_length(), $urandom_range(0, 4) == 0);
      end else if (pick < 63) begin
        queue_frame(8'($urandom), 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)), 1'b0);
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 12)) queue_tick();
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 3)) queue_byte(SYNC_BYTE_1);
        if ($urandom_range(0, 1) == 0) begin
          queue_byte(8'($urandom));
        end else begin
          queue_frame(8'($urandom), pick_length(), 1'b0);
        end
      end else begin
        queue_byte(SYNC_BYTE_1);
        queue_byte(SYNC_BYTE_2);
        queue_byte(8'($urandom));
        queue_byte(8'($urandom_range(2, 10)));
        queue_byte(8'($urandom));
      end
    end
  endtask

  // Wait until every queued word is in and every status word is back.
  task automatic wait_drained();
    while (byte_stream_q.size() != 0 || in_valid_i || expected_status.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Read the timeout register and compare it with the bench copy.
  task automatic readback_timeout();
    logic [31:0] got;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {REG_IDX_TIMEOUT, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    check_field("timeout register readback", timeout_copy, got);
  endtask

  // Write the timeout register with a setup and an access cycle.
  task automatic set_timeout(input logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {REG_IDX_TIMEOUT, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    timeout_copy = value;
    readback_timeout();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    cmd_i = CMD_BYTE;
    rx_byte_i = '0;
    out_stall_i = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    readback_timeout();

    // Directed words with the reset timeout: tick, noise at both byte
    // extremes, repeated sync byte before an empty good frame, a broken
    // header, two oversize lengths and a frame with a bad CRC.
    queue_tick();
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(SYNC_BYTE_1);
    queue_frame(8'h3C, 8'd0, 1'b0);
    queue_tick();
    queue_byte(SYNC_BYTE_1);
    queue_byte(8'h12);
    queue_frame(8'hFF, 8'(MAX_PAYLOAD_DEF + 1), 1'b0);
    queue_frame(8'h00, 8'hFF, 1'b0);
    queue_frame(8'h81, 8'd1, 1'b1);
    wait_drained();

    // Random traffic over several timeout settings, extremes first.
    tick_mix = 1'b1;
    set_timeout(32'h0000_0000);
    queue_random_traffic(260);
    wait_drained();
    set_timeout(32'hFFFF_FFFF);
    queue_random_traffic(260);
    wait_drained();
    set_timeout(32'($urandom_range(2, 25)));
    queue_random_traffic(200);
    wait_drained();

    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    set_timeout(32'($urandom_range(1, 40)));
    queue_random_traffic(110);
    wait_drained();

    if (expected_status.size() != 0) begin
      $display("%0t: %0d status words never returned", $time, expected_status.size());
      errors++;
    end
    $display("Checked %0d status words: %0d good frames, %0d CRC errors, %0d length errors.",
             results_checked, n_good, n_crc_err, n_len_err);
    $display("Time base reached %0d ms over five online timeout settings.", ms_now);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/fprx_pkg.sv
design/framed_packet_receiver_crc16.sv
test/testbench.sv
